// File: design/hhpp_pkg.sv
`default_nettype none

package hhpp_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_END    = 2'd1;
   localparam logic [1:0] KIND_COMMIT = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   // Parts of the header value.
   localparam logic [2:0] PART_TYPE     = 3'd0;
   localparam logic [2:0] PART_SUBTYPE  = 3'd1;
   localparam logic [2:0] PART_NAME     = 3'd2;
   localparam logic [2:0] PART_VALUE    = 3'd3;
   localparam logic [2:0] PART_CHARSET  = 3'd4;
   localparam logic [2:0] PART_LANGUAGE = 3'd5;

   // Completion status carried by the done result.
   localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_FAILED    = 2'd2;

   // Header kind sampled at the first byte.
   localparam logic HDR_CONTENT_TYPE        = 1'b0;
   localparam logic HDR_CONTENT_DISPOSITION = 1'b1;

   typedef struct packed {
      logic [7:0] header_byte;
      logic       header_kind;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [2:0] part;
      logic [7:0] data;
      logic       cleared;
      logic [1:0] status;
      logic       run_last;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/http_header_parameter_parser_core.sv
`default_nettype none

// Channel   Direction  Payload                  Handshake
// req       in         hhpp_pkg::req_type       req_valid / req_ready
// rsp       out        hhpp_pkg::rsp_type       rsp_valid / rsp_ready
//
// Each request byte is parsed in the cycle it is accepted: the parser state
// registers advance and the zero to three results it causes are written into
// an eight-entry result queue at once. The queue drains one result per cycle
// through its single read port while rsp_ready is high. A request is taken
// whenever at least three queue entries are free, so input keeps flowing
// while a result waits on a stalled rsp side.
// Reset is synchronous and active high; it empties the queue and returns the
// parser to waiting for the first byte of a header.

module http_header_parameter_parser_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire hhpp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output hhpp_pkg::rsp_type      rsp_data
);

   // Parser phases.
   typedef enum logic [4:0] {
      PH_WAIT, PH_TYPE, PH_SUBTYPE, PH_DTYPE, PH_AFTER, PH_NAME, PH_EQ,
      PH_EQ_EXT, PH_VAL_START, PH_TOKVAL, PH_QUOTED, PH_EXT_START,
      PH_CHARSET, PH_LANG, PH_EXTVAL, PH_PCT1, PH_PCT2, PH_SKIP_STOP,
      PH_SKIP_FAIL
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       kind;
      logic       esc;
      logic [3:0] hex;
      logic       open;
   } parser_state_type;

   // One pass through the phase logic: it may emit up to two results and may
   // ask for the same byte to be looked at again in the new phase.
   typedef struct packed {
      parser_state_type  st;
      logic              again;
      logic [1:0]        n;
      hhpp_pkg::rsp_type r0;
      hhpp_pkg::rsp_type r1;
   } step_type;

   localparam int          RSP_DEPTH = 8;
   localparam int          PTR_W     = $clog2(RSP_DEPTH);
   localparam int          CNT_W     = PTR_W + 1;
   localparam int          MAX_RES   = 3;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CTL_HI = 8'd31;
   localparam logic [7:0] CH_DEL    = 8'd127;

   function automatic logic is_ctl(input logic [7:0] c);
      return (c <= CH_CTL_HI) || (c == CH_DEL);
   endfunction

   // HTTP separators: ( ) < > @ , ; : \ " / [ ] ? = { } space tab.
   function automatic logic is_sep(input logic [7:0] c);
      logic r;
      case (c)
         8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
         8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20,
         8'h09: begin
            r = 1'b1;
         end
         default: begin
            r = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic logic is_tok(input logic [7:0] c);
      return !is_sep(c) && !is_ctl(c);
   endfunction

   function automatic logic is_lwsp(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   // Charset characters: alphanumerics and ! # $ % & + - ^ _ ` { } ~.
   function automatic logic is_charsetc(input logic [7:0] c);
      logic r;
      case (c)
         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2B, 8'h2D, 8'h5E, 8'h5F,
         8'h60, 8'h7B, 8'h7D, 8'h7E: begin
            r = 1'b1;
         end
         default: begin
            r = is_alnum(c);
         end
      endcase
      return r;
   endfunction

   // Ext-value attribute characters: alphanumerics and ! # $ & + - . ^ _ ` | ~.
   function automatic logic is_attr(input logic [7:0] c);
      logic r;
      case (c)
         8'h21, 8'h23, 8'h24, 8'h26, 8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F,
         8'h60, 8'h7C, 8'h7E: begin
            r = 1'b1;
         end
         default: begin
            r = is_alnum(c);
         end
      endcase
      return r;
   endfunction

   // Returns the digit value in the low bits; the top bit flags a non-hex byte.
   function automatic logic [4:0] hexval(input logic [7:0] c);
      logic [4:0] r;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         r = 5'(c - 8'h30);
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         r = 5'(c - 8'h61 + 8'd10);
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         r = 5'(c - 8'h41 + 8'd10);
      end else begin
         r = 5'd16;
      end
      return r;
   endfunction

   function automatic logic [7:0] lower(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
   endfunction

   function automatic hhpp_pkg::rsp_type mk(input logic [1:0] k, input logic [2:0] p,
                                            input logic [7:0] d, input logic cl,
                                            input logic [1:0] s);
      hhpp_pkg::rsp_type r;
      r.result_kind = k;
      r.part        = p;
      r.data        = d;
      r.cleared     = cl;
      r.status      = s;
      r.run_last    = 1'b0;
      return r;
   endfunction

   function automatic step_type one_char(input step_type o, input logic [2:0] p,
                                         input logic [7:0] d);
      step_type r;
      r    = o;
      r.r0 = mk(hhpp_pkg::KIND_CHAR, p, d, 1'b0, hhpp_pkg::STATUS_COMPLETE);
      r.n  = 2'd1;
      return r;
   endfunction

   function automatic step_type one_end(input step_type o, input logic [2:0] p);
      step_type r;
      r    = o;
      r.r0 = mk(hhpp_pkg::KIND_END, p, 8'd0, 1'b0, hhpp_pkg::STATUS_COMPLETE);
      r.n  = 2'd1;
      return r;
   endfunction

   // The done result also returns the parser to waiting for a new header.
   function automatic step_type finish(input step_type o, input logic [2:0] s);
      step_type r;
      r          = o;
      r.r0       = mk(hhpp_pkg::KIND_DONE, hhpp_pkg::PART_TYPE, 8'd0, 1'b0, s[1:0]);
      r.n        = 2'd1;
      r.st.phase = PH_WAIT;
      r.st.esc   = 1'b0;
      r.st.hex   = 4'd0;
      r.st.open  = 1'b0;
      return r;
   endfunction

   // Closing a value sends its part end and the commit of the parameter.
   function automatic step_type close_value(input step_type o, input logic cl);
      step_type r;
      r          = o;
      r.r0       = mk(hhpp_pkg::KIND_END, hhpp_pkg::PART_VALUE, 8'd0, cl,
                      hhpp_pkg::STATUS_COMPLETE);
      r.r1       = mk(hhpp_pkg::KIND_COMMIT, hhpp_pkg::PART_TYPE, 8'd0, 1'b0,
                      hhpp_pkg::STATUS_COMPLETE);
      r.n        = 2'd2;
      r.st.esc   = 1'b0;
      r.st.phase = PH_AFTER;
      return r;
   endfunction

   function automatic step_type step(input parser_state_type st, input logic [7:0] c,
                                     input logic k);
      step_type   o;
      logic [4:0] h;
      o       = '0;
      o.st    = st;
      h       = hexval(c);
      case (st.phase)
         PH_WAIT: begin
            o.st.kind  = k;
            o.st.phase = (k == hhpp_pkg::HDR_CONTENT_DISPOSITION) ? PH_DTYPE : PH_TYPE;
            o.st.esc   = 1'b0;
            o.st.hex   = 4'd0;
            o.st.open  = 1'b0;
            o.again    = 1'b1;
         end
         PH_TYPE: begin
            if (is_tok(c)) begin
               o = one_char(o, hhpp_pkg::PART_TYPE, c);
            end else if (c == CH_SLASH) begin
               o          = one_end(o, hhpp_pkg::PART_TYPE);
               o.st.phase = PH_SUBTYPE;
            end else if (c == CH_NUL) begin
               o = finish(o, {1'b0, hhpp_pkg::STATUS_FAILED});
            end else begin
               o.st.phase = PH_SKIP_FAIL;
            end
         end
         PH_SUBTYPE: begin
            if (is_tok(c)) begin
               o = one_char(o, hhpp_pkg::PART_SUBTYPE, c);
            end else begin
               o          = one_end(o, hhpp_pkg::PART_SUBTYPE);
               o.st.phase = PH_AFTER;
               o.again    = 1'b1;
            end
         end
         PH_DTYPE: begin
            if (is_tok(c)) begin
               o = one_char(o, hhpp_pkg::PART_TYPE, lower(c));
            end else begin
               o          = one_end(o, hhpp_pkg::PART_TYPE);
               o.st.phase = PH_AFTER;
               o.again    = 1'b1;
            end
         end
         PH_AFTER: begin
            if (c == CH_NUL) begin
               o = finish(o, {1'b0, hhpp_pkg::STATUS_COMPLETE});
            end else if (is_lwsp(c)) begin
               o.st.phase = PH_AFTER;
            end else if (c == CH_SEMI) begin
               o.st.phase = PH_NAME;
               o.st.open  = 1'b0;
            end else begin
               o.st.phase = PH_SKIP_STOP;
            end
         end
         PH_NAME: begin
            if (!st.open && is_lwsp(c)) begin
               o.st.phase = PH_NAME;
            end else if (is_tok(c) && !(st.kind && (c == CH_STAR))) begin
               o         = one_char(o, hhpp_pkg::PART_NAME, lower(c));
               o.st.open = 1'b1;
            end else begin
               o         = one_end(o, hhpp_pkg::PART_NAME);
               o.st.open = 1'b0;
               if (st.kind && (c == CH_STAR)) begin
                  o.st.phase = PH_EQ_EXT;
               end else begin
                  o.st.phase = PH_EQ;
                  o.again    = 1'b1;
               end
            end
         end
         PH_EQ, PH_EQ_EXT: begin
            if (is_lwsp(c)) begin
               o.st.phase = st.phase;
            end else if (c == CH_EQUAL) begin
               o.st.phase = (st.phase == PH_EQ) ? PH_VAL_START : PH_EXT_START;
            end else if (c == CH_NUL) begin
               o = finish(o, {1'b0, hhpp_pkg::STATUS_MALFORMED});
            end else begin
               o.st.phase = PH_SKIP_STOP;
            end
         end
         PH_VAL_START: begin
            if (is_lwsp(c)) begin
               o.st.phase = PH_VAL_START;
            end else if (c == CH_NUL) begin
               o = finish(o, {1'b0, hhpp_pkg::STATUS_MALFORMED});
            end else if (c == CH_DQUOTE) begin
               o.st.phase = PH_QUOTED;
               o.st.esc   = 1'b0;
            end else begin
               o.st.phase = PH_TOKVAL;
               o.again    = 1'b1;
            end
         end
         PH_TOKVAL: begin
            if (is_tok(c)) begin
               o = one_char(o, hhpp_pkg::PART_VALUE, c);
            end else begin
               o       = close_value(o, 1'b0);
               o.again = 1'b1;
            end
         end
         PH_QUOTED: begin
            // A control byte other than tab cuts the quoted string short.
            if (is_ctl(c) && (c != CH_TAB)) begin
               o       = close_value(o, 1'b1);
               o.again = 1'b1;
            end else if (st.esc) begin
               o        = one_char(o, hhpp_pkg::PART_VALUE, c);
               o.st.esc = 1'b0;
            end else if (c == CH_DQUOTE) begin
               o = close_value(o, 1'b0);
            end else if (c == CH_BSLASH) begin
               o.st.esc = 1'b1;
            end else begin
               o = one_char(o, hhpp_pkg::PART_VALUE, c);
            end
         end
         PH_EXT_START: begin
            if (is_lwsp(c)) begin
               o.st.phase = PH_EXT_START;
            end else if (c == CH_NUL) begin
               o = finish(o, {1'b0, hhpp_pkg::STATUS_MALFORMED});
            end else begin
               o.st.phase = PH_CHARSET;
               o.again    = 1'b1;
            end
         end
         PH_CHARSET: begin
            if (is_charsetc(c)) begin
               o = one_char(o, hhpp_pkg::PART_CHARSET, c);
            end else if (c == CH_APOS) begin
               o          = one_end(o, hhpp_pkg::PART_CHARSET);
               o.st.phase = PH_LANG;
            end else if (c == CH_NUL) begin
               o = finish(o, {1'b0, hhpp_pkg::STATUS_MALFORMED});
            end else begin
               o.st.phase = PH_SKIP_STOP;
            end
         end
         PH_LANG: begin
            if (c == CH_APOS) begin
               o          = one_end(o, hhpp_pkg::PART_LANGUAGE);
               o.st.phase = PH_EXTVAL;
            end else if (c == CH_NUL) begin
               o = finish(o, {1'b0, hhpp_pkg::STATUS_MALFORMED});
            end else begin
               o = one_char(o, hhpp_pkg::PART_LANGUAGE, c);
            end
         end
         PH_EXTVAL: begin
            if (is_attr(c)) begin
               o = one_char(o, hhpp_pkg::PART_VALUE, c);
            end else if (c == CH_PCT) begin
               o.st.phase = PH_PCT1;
            end else begin
               o       = close_value(o, 1'b0);
               o.again = 1'b1;
            end
         end
         PH_PCT1: begin
            if (!h[4]) begin
               o.st.hex   = h[3:0];
               o.st.phase = PH_PCT2;
            end else begin
               o       = close_value(o, 1'b0);
               o.again = 1'b1;
            end
         end
         PH_PCT2: begin
            if (!h[4]) begin
               o          = one_char(o, hhpp_pkg::PART_VALUE, {st.hex, h[3:0]});
               o.st.hex   = 4'd0;
               o.st.phase = PH_EXTVAL;
            end else begin
               o.st.hex = 4'd0;
               o        = close_value(o, 1'b0);
               o.again  = 1'b1;
            end
         end
         PH_SKIP_STOP: begin
            if (c == CH_NUL) begin
               o = finish(o, {1'b0, hhpp_pkg::STATUS_MALFORMED});
            end
         end
         PH_SKIP_FAIL: begin
            if (c == CH_NUL) begin
               o = finish(o, {1'b0, hhpp_pkg::STATUS_FAILED});
            end
         end
         default: begin
            o.st.phase = PH_WAIT;
            o.again    = 1'b1;
         end
      endcase
      return o;
   endfunction

   parser_state_type  st_ff, st_in;
   hhpp_pkg::rsp_type fifo_ff [RSP_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   hhpp_pkg::rsp_type res [MAX_RES];
   logic [1:0]        res_n;
   logic              req_fire, rsp_fire;

   assign req_ready = (count_ff <= CNT_W'(RSP_DEPTH - MAX_RES));
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   // The byte is walked through at most three chained phase passes; a byte is
   // re-examined when a phase hands it on, as on a delimiter of the next part.
   always_comb begin
      parser_state_type cur;
      step_type         so;
      logic             go;
      cur   = st_ff;
      go    = 1'b1;
      res_n = 2'd0;
      for (int i = 0; i < MAX_RES; i++) begin
         res[i] = '0;
      end
      for (int i = 0; i < MAX_RES; i++) begin
         if (go) begin
            so  = step(cur, req_data.header_byte, req_data.header_kind);
            cur = so.st;
            if ((so.n != 2'd0) && (res_n < 2'(MAX_RES))) begin
               res[res_n] = so.r0;
               res_n      = res_n + 2'd1;
            end
            if ((so.n == 2'd2) && (res_n < 2'(MAX_RES))) begin
               res[res_n] = so.r1;
               res_n      = res_n + 2'd1;
            end
            go = so.again;
         end
      end
      if (res_n != 2'd0) begin
         res[res_n - 2'd1].run_last = 1'b1;
      end
      st_in = cur;
   end

   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         count_in = count_in + CNT_W'(res_n);
      end
      if (rsp_fire) begin
         count_in = count_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= '{phase: PH_WAIT, kind: 1'b0, esc: 1'b0, hex: 4'd0, open: 1'b0};
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            st_ff     <= st_in;
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(res_n);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
      // Queue entries are payload only and need no reset.
      if (req_fire) begin
         for (int j = 0; j < MAX_RES; j++) begin
            if (2'(j) < res_n) begin
               fifo_ff[wr_ptr_ff + PTR_W'(j)] <= res[j];
            end
         end
      end
   end

`ifndef SYNTHESIS
   // The queue never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // An empty queue has its pointers together.
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("result queue pointers disagree with count");

   // A terminating zero byte always ends the header and rearms the parser.
   a_nul_done: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.header_byte == CH_NUL)) |=> (st_ff.phase == PH_WAIT))
      else $error("zero byte did not finish the header");

   // The done result is always the last one its byte causes.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_kind == hhpp_pkg::KIND_DONE)) |-> rsp_data.run_last)
      else $error("done result not marked last");

   // Only character results carry data.
   a_data_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_kind != hhpp_pkg::KIND_CHAR)) |->
         (rsp_data.data == 8'd0))
      else $error("data set on a non-character result");
`endif

endmodule

`default_nettype wire
